// ----- hdl/aiocm_pkg.sv -----
// shared types, codes and helper functions of the analog i/o channel manager
`default_nettype none

package aiocm_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W     = $clog2(CHANNELS);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_SERVICE = 2'd0;
    localparam logic [1:0] CMD_PARAM   = 2'd1;
    localparam logic [1:0] CMD_CONFIG  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_LED    = 3'd0;
    localparam logic [2:0] KIND_REPORT = 3'd1;
    localparam logic [2:0] KIND_DAC    = 3'd2;
    localparam logic [2:0] KIND_MODE   = 3'd3;
    localparam logic [2:0] KIND_ACK    = 3'd4;

    // channel modes
    localparam logic [2:0] MODE_BIP_IN  = 3'd0;
    localparam logic [2:0] MODE_UNI_IN  = 3'd1;
    localparam logic [2:0] MODE_BIP_OUT = 3'd4;
    localparam logic [2:0] MODE_UNI_OUT = 3'd5;

    // register indexes
    localparam logic [1:0] REG_PARAM_BASE = 2'd0;
    localparam logic [1:0] REG_PARAM_LAST = 2'd1;
    localparam logic [1:0] REG_HYSTERESIS = 2'd2;

    localparam logic [7:0]  PARAM_BASE_RST = 8'd0;
    localparam logic [7:0]  PARAM_LAST_RST = 8'd15;
    localparam logic [6:0]  HYSTERESIS_RST = 7'd3;
    localparam logic [11:0] LEVEL_MAX      = 12'hfff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_SEND0,
        ST_SEND1
    } state_t;

    typedef struct packed {
        logic [7:0] param_base;
        logic [7:0] param_last;
        logic [6:0] hysteresis;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic exec;
        logic sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] exec_cnt;
        logic [1:0] res_cnt;
    } dp_stat_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [3:0]        led_index;
        logic [11:0]       led_level;
        logic [7:0]        report_id;
        logic signed [15:0] out_value;
        logic [CH_W-1:0]   out_channel;
        logic [2:0]        out_mode;
    } res_t;

    // raw channel code to converter channel, out of range when the code is above 23
    function automatic logic [7:0] map_code(input logic [7:0] c);
        logic [7:0] m;
        m = (c > 8'd7) ? (8'd23 - c) : c;
        return m;
    endfunction

    function automatic logic [11:0] led_level_f(input logic [2:0] mode,
                                                input logic signed [15:0] v);
        logic signed [16:0] d;
        logic [16:0]        ad;
        logic [17:0]        r2;
        logic [11:0]        res;
        d  = $signed({v[15], v}) - 17'sd2048;
        ad = d[16] ? 17'(-d) : 17'(d);
        r2 = {ad, 1'b0};
        if (mode == MODE_BIP_IN || mode == MODE_BIP_OUT)
        begin
            res = (r2 > 18'd4095) ? LEVEL_MAX : r2[11:0];
        end
        else if (v[15])
        begin
            res = 12'd0;
        end
        else if (v[14:12] != 3'd0)
        begin
            res = LEVEL_MAX;
        end
        else
        begin
            res = v[11:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/aiocm_regs.sv -----
// configuration register file behind the apb port
`default_nettype none

module aiocm_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [aiocm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [aiocm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [aiocm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output aiocm_pkg::cfg_t                        cfg
);
    import aiocm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PARAM_BASE: cfg_next.param_base = pwdata[7:0];
                REG_PARAM_LAST: cfg_next.param_last = pwdata[7:0];
                REG_HYSTERESIS: cfg_next.hysteresis = pwdata[6:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.param_base <= PARAM_BASE_RST;
            cfg_reg.param_last <= PARAM_LAST_RST;
            cfg_reg.hysteresis <= HYSTERESIS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PARAM_BASE: prdata = {24'd0, cfg_reg.param_base};
            REG_PARAM_LAST: prdata = {24'd0, cfg_reg.param_last};
            REG_HYSTERESIS: prdata = {25'd0, cfg_reg.hysteresis};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/aiocm_ctrl.sv -----
// controller state machine sequencing capture, decode, execute and result transactions
`default_nettype none

module aiocm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic                      m_axis_tlast,
    output aiocm_pkg::ctl_cmd_t       cmd,
    input  wire aiocm_pkg::dp_stat_t  stat
);
    import aiocm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = (stat.exec_cnt == 2'd0) ? ST_IDLE : ST_SEND0;
            end
            ST_SEND0:
            begin
                if (m_axis_tready)
                begin
                    state_next = (stat.res_cnt == 2'd2) ? ST_SEND1 : ST_IDLE;
                end
            end
            ST_SEND1:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tlast  = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_SEND0:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = (stat.res_cnt != 2'd2);
            end
            ST_SEND1:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = 1'b1;
                cmd.sel       = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/aiocm_dp.sv -----
// datapath: item capture, channel decode, channel state tables and result buffer
`default_nettype none

module aiocm_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [aiocm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic [1:0]                          s_axis_tuser,
    output logic      [aiocm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic      [2:0]                          m_axis_tuser,
    input  wire aiocm_pkg::cfg_t                     cfg,
    input  wire aiocm_pkg::ctl_cmd_t                 cmd,
    output aiocm_pkg::dp_stat_t                      stat
);
    import aiocm_pkg::*;

    // captured item
    logic [1:0]         cmd_reg;
    logic [CH_W-1:0]    channel_reg;
    logic [7:0]         pid_reg;
    logic signed [15:0] value_reg;
    logic [7:0]         cfg_ch_reg;
    logic [7:0]         new_mode_reg;

    // decoded target
    logic [CH_W-1:0]    tgt_reg;
    logic               ok_reg;
    logic [CH_W-1:0]    tgt_next;
    logic               ok_next;

    // channel state tables
    logic [2:0]         mode_reg  [CHANNELS];
    logic signed [15:0] outv_reg  [CHANNELS];
    logic [11:0]        inv_reg   [CHANNELS];
    logic [6:0]         rep_reg   [CHANNELS];

    // result buffer
    res_t               res0_reg;
    res_t               res1_reg;
    logic [1:0]         cnt_reg;

    // execute stage
    logic [2:0]         mode_cur;
    logic signed [15:0] outv_cur;
    logic [11:0]        inv_cur;
    logic [6:0]         rep_cur;
    logic [11:0]        smp;
    logic [6:0]         cc;
    logic signed [7:0]  cdiff;
    logic [6:0]         cabs;
    logic [2:0]         mode_new;
    logic signed [15:0] v2;
    logic               fa;
    logic               fb;
    res_t               ra;
    res_t               rb;
    logic               wr_mode;
    logic               wr_outv;
    logic               wr_inv;
    logic               wr_rep;
    logic               mode_ok;

    logic [7:0]         pid_off;
    logic [7:0]         pid_map;
    logic [7:0]         cfg_map;
    res_t               res_sel;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg      <= s_axis_tuser;
            channel_reg  <= s_axis_tdata[3:0];
            pid_reg      <= s_axis_tdata[11:4];
            value_reg    <= s_axis_tdata[27:12];
            cfg_ch_reg   <= s_axis_tdata[35:28];
            new_mode_reg <= s_axis_tdata[43:36];
        end
    end

    // decode
    assign pid_off = pid_reg - cfg.param_base;
    assign pid_map = map_code(pid_off);
    assign cfg_map = map_code(cfg_ch_reg);

    always_comb
    begin
        tgt_next = channel_reg;
        ok_next  = 1'b0;
        case (cmd_reg)
            CMD_SERVICE:
            begin
                tgt_next = channel_reg;
                ok_next  = 1'b1;
            end
            CMD_PARAM:
            begin
                tgt_next = pid_map[CH_W-1:0];
                ok_next  = (pid_reg >= cfg.param_base) && (pid_reg <= cfg.param_last)
                           && (pid_map[7:CH_W] == '0);
            end
            CMD_CONFIG:
            begin
                tgt_next = cfg_map[CH_W-1:0];
                ok_next  = (cfg_map[7:CH_W] == '0);
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.decode)
        begin
            ok_reg <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            tgt_reg <= tgt_next;
        end
    end

    // execute
    assign mode_cur = mode_reg[tgt_reg];
    assign outv_cur = outv_reg[tgt_reg];
    assign inv_cur  = inv_reg[tgt_reg];
    assign rep_cur  = rep_reg[tgt_reg];
    assign smp      = value_reg[11:0];
    assign cc       = smp[11:5];
    assign cdiff    = $signed({1'b0, cc}) - $signed({1'b0, rep_cur});
    assign cabs     = cdiff[7] ? 7'(-cdiff) : cdiff[6:0];
    assign mode_ok  = (new_mode_reg == 8'(MODE_BIP_IN)) || (new_mode_reg == 8'(MODE_UNI_IN))
                      || (new_mode_reg == 8'(MODE_BIP_OUT))
                      || (new_mode_reg == 8'(MODE_UNI_OUT));

    always_comb
    begin
        fa       = 1'b0;
        fb       = 1'b0;
        ra       = '0;
        rb       = '0;
        wr_mode  = 1'b0;
        wr_outv  = 1'b0;
        wr_inv   = 1'b0;
        wr_rep   = 1'b0;
        mode_new = mode_cur;
        v2       = value_reg;
        if (ok_reg)
        begin
            case (cmd_reg)
                CMD_SERVICE:
                begin
                    if (!mode_cur[2])
                    begin
                        fa           = (inv_cur != smp);
                        wr_inv       = fa;
                        ra.kind      = KIND_LED;
                        ra.led_index = 4'(CHANNELS - 1) - tgt_reg;
                        ra.led_level = led_level_f(mode_cur, {4'd0, smp});
                        fb           = (cabs > cfg.hysteresis);
                        wr_rep       = fb;
                        rb.kind      = KIND_REPORT;
                        rb.report_id = cfg.param_base + map_code(8'(tgt_reg));
                        rb.out_value = {4'd0, smp};
                    end
                    else
                    begin
                        fb             = 1'b1;
                        rb.kind        = KIND_DAC;
                        rb.out_value   = outv_cur;
                        rb.out_channel = tgt_reg;
                    end
                end
                CMD_PARAM:
                begin
                    if (!mode_cur[2])
                    begin
                        mode_new = value_reg[15] ? MODE_BIP_OUT : MODE_UNI_OUT;
                        fa       = 1'b1;
                    end
                    wr_mode        = 1'b1;
                    ra.kind        = KIND_MODE;
                    ra.out_channel = tgt_reg;
                    ra.out_mode    = mode_new;
                    if (mode_new == MODE_BIP_OUT)
                    begin
                        v2 = value_reg + 16'sd2048;
                    end
                    fb           = (outv_cur != v2);
                    wr_outv      = fb;
                    rb.kind      = KIND_LED;
                    rb.led_index = 4'(CHANNELS - 1) - tgt_reg;
                    rb.led_level = led_level_f(mode_new, v2);
                end
                CMD_CONFIG:
                begin
                    if (mode_ok)
                    begin
                        mode_new = new_mode_reg[2:0];
                        fa       = 1'b1;
                    end
                    wr_mode        = 1'b1;
                    ra.kind        = KIND_MODE;
                    ra.out_channel = tgt_reg;
                    ra.out_mode    = mode_new;
                    fb             = 1'b1;
                    rb.kind        = KIND_ACK;
                    rb.out_channel = tgt_reg;
                    rb.out_mode    = mode_new;
                end
                default:
                begin
                    fa = 1'b0;
                    fb = 1'b0;
                end
            endcase
        end
    end

    assign stat.exec_cnt = {1'b0, fa} + {1'b0, fb};
    assign stat.res_cnt  = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_reg[i] <= MODE_UNI_IN;
                outv_reg[i] <= '0;
                inv_reg[i]  <= '0;
                rep_reg[i]  <= '0;
            end
        end
        else if (cmd.exec)
        begin
            cnt_reg <= stat.exec_cnt;
            if (wr_mode)
            begin
                mode_reg[tgt_reg] <= mode_new;
            end
            if (wr_outv)
            begin
                outv_reg[tgt_reg] <= v2;
            end
            if (wr_inv)
            begin
                inv_reg[tgt_reg] <= smp;
            end
            if (wr_rep)
            begin
                rep_reg[tgt_reg] <= cc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res0_reg <= fa ? ra : rb;
            res1_reg <= rb;
        end
    end

    assign res_sel      = cmd.sel ? res1_reg : res0_reg;
    assign m_axis_tuser = res_sel.kind;
    assign m_axis_tdata = {1'b0, res_sel.out_mode, res_sel.out_channel, res_sel.out_value,
                           res_sel.report_id, res_sel.led_level, res_sel.led_index};

endmodule

`default_nettype wire

// ----- hdl/analog_io_channel_manager_core.sv -----
// analog i/o channel manager: top level with stream ports and apb configuration
// an item is accepted in idle, decoded in the following cycle and executed in the one after;
// the first result is offered from the send state that follows execute and held until taken
// a new item is accepted only after every result of the last one has been taken
// the two-step decode/execute sequence runs through the state tables
// async reset: idle, tables to unipolar input and zero, registers to 0, 15, 3
`default_nettype none

module analog_io_channel_manager_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // channel, parameter_id, value, config_channel, new_mode, 4 zero bits
    input  wire logic [aiocm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // led_index, led_level, report_id, out_value, out_channel, out_mode, 1 zero bit
    output logic      [aiocm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // kind
    output logic      [2:0]                        m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [aiocm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [aiocm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [aiocm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);
    import aiocm_pkg::*;

    cfg_t     cfg;
    ctl_cmd_t cmd;
    dp_stat_t stat;

    aiocm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aiocm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

    aiocm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

// ----- hdl/aiocm_chk.sv -----
// port-level checker for the channel manager and its bind to the top level
`default_nettype none

module aiocm_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic                              m_axis_tlast,
    input wire logic [aiocm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire logic [2:0]                        m_axis_tuser,
    input wire logic                              pready
);

    // one item in flight: no input transaction while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
        else $error("not busy after input transaction");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after last");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind analog_io_channel_manager_core aiocm_chk u_chk (.*);

`default_nettype wire

// ----- tb/aiocm_result_checker.sv -----
`timescale 1ns / 100ps
// result predictor and comparator for the analog i/o channel manager streams
module aiocm_result_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic [aiocm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic [1:0]                          s_axis_tuser,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [aiocm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic [2:0]                          m_axis_tuser,
    input  wire logic                                m_axis_tlast,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [aiocm_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [aiocm_pkg::APB_DATA_W-1:0]    pwdata,
    input  wire logic                                pready,
    output int                                       mismatch_count,
    output int                                       pending_count
);
    import aiocm_pkg::*;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         led_index;
        logic [11:0]        led_level;
        logic [7:0]         report_id;
        logic signed [15:0] out_value;
        logic [3:0]         out_channel;
        logic [2:0]         out_mode;
        logic               last;
    } result_t;

    logic [2:0]         mode_tbl [CHANNELS];
    logic signed [15:0] drive_tbl [CHANNELS];
    logic [11:0]        sample_tbl [CHANNELS];
    logic [6:0]         coarse_tbl [CHANNELS];
    logic [7:0]         base_id;
    logic [7:0]         last_id;
    logic [6:0]         hyst;
    result_t            expected_q [$];
    int                 error_total;

    // raw code to converter channel, CHANNELS when the code maps to none
    function automatic int map_to_channel(input logic [7:0] code);
        if (code <= 8'd7)
        begin
            return int'(code);
        end
        else if (code <= 8'd23)
        begin
            return 23 - int'(code);
        end
        return CHANNELS;
    endfunction

    function automatic logic [11:0] grayscale(input logic [2:0] mode, input int v);
        int r;
        if (mode == MODE_BIP_IN || mode == MODE_BIP_OUT)
        begin
            r = (v >= 2048) ? 2 * (v - 2048) : 2 * (2048 - v);
        end
        else
        begin
            r = v;
        end
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 4095)
        begin
            r = 4095;
        end
        return 12'(r);
    endfunction

    function automatic result_t make_result(input logic [2:0] kind, input logic [3:0] led_index,
                                            input logic [11:0] led_level,
                                            input logic [7:0] report_id,
                                            input logic [15:0] out_value,
                                            input logic [3:0] out_channel,
                                            input logic [2:0] out_mode);
        result_t r;
        r.kind        = kind;
        r.led_index   = led_index;
        r.led_level   = led_level;
        r.report_id   = report_id;
        r.out_value   = out_value;
        r.out_channel = out_channel;
        r.out_mode    = out_mode;
        r.last        = 1'b0;
        return r;
    endfunction

    task automatic compute_channel_results(input logic [1:0] cmd, input logic [47:0] d);
        logic [3:0]         ch;
        logic [7:0]         pid;
        logic signed [15:0] val;
        logic [7:0]         code;
        logic [7:0]         mode_req;
        logic [11:0]        smp;
        logic [6:0]         coarse;
        int                 diff;
        int                 mch;
        result_t            batch [$];
        ch       = d[3:0];
        pid      = d[11:4];
        val      = d[27:12];
        code     = d[35:28];
        mode_req = d[43:36];
        case (cmd)
            CMD_SERVICE:
            begin
                if (mode_tbl[ch] < MODE_BIP_OUT)
                begin
                    smp = val[11:0];
                    if (sample_tbl[ch] != smp)
                    begin
                        sample_tbl[ch] = smp;
                        batch.push_back(make_result(KIND_LED, 4'd15 - ch,
                            grayscale(mode_tbl[ch], int'(smp)), 8'd0, 16'd0, 4'd0, 3'd0));
                    end
                    coarse = smp[11:5];
                    diff = int'(coarse) - int'(coarse_tbl[ch]);
                    if (diff < 0)
                    begin
                        diff = -diff;
                    end
                    if (diff > int'(hyst))
                    begin
                        batch.push_back(make_result(KIND_REPORT, 4'd0, 12'd0,
                            8'(int'(base_id) + map_to_channel({4'd0, ch})), {4'd0, smp},
                            4'd0, 3'd0));
                        coarse_tbl[ch] = coarse;
                    end
                end
                else
                begin
                    batch.push_back(make_result(KIND_DAC, 4'd0, 12'd0, 8'd0, drive_tbl[ch],
                        ch, 3'd0));
                end
            end
            CMD_PARAM:
            begin
                if (pid >= base_id && pid <= last_id)
                begin
                    mch = map_to_channel(pid - base_id);
                    if (mch < CHANNELS)
                    begin
                        if (mode_tbl[mch] < MODE_BIP_OUT)
                        begin
                            mode_tbl[mch] = val[15] ? MODE_BIP_OUT : MODE_UNI_OUT;
                            batch.push_back(make_result(KIND_MODE, 4'd0, 12'd0, 8'd0, 16'd0,
                                4'(mch), mode_tbl[mch]));
                        end
                        if (mode_tbl[mch] == MODE_BIP_OUT)
                        begin
                            val = val + 16'sd2048;
                        end
                        if (drive_tbl[mch] != val)
                        begin
                            drive_tbl[mch] = val;
                            batch.push_back(make_result(KIND_LED, 4'(15 - mch),
                                grayscale(mode_tbl[mch], int'(val)), 8'd0, 16'd0, 4'd0, 3'd0));
                        end
                    end
                end
            end
            CMD_CONFIG:
            begin
                mch = map_to_channel(code);
                if (mch < CHANNELS)
                begin
                    if (mode_req == 8'(MODE_BIP_IN) || mode_req == 8'(MODE_UNI_IN)
                        || mode_req == 8'(MODE_BIP_OUT) || mode_req == 8'(MODE_UNI_OUT))
                    begin
                        mode_tbl[mch] = mode_req[2:0];
                        batch.push_back(make_result(KIND_MODE, 4'd0, 12'd0, 8'd0, 16'd0,
                            4'(mch), mode_tbl[mch]));
                    end
                    batch.push_back(make_result(KIND_ACK, 4'd0, 12'd0, 8'd0, 16'd0,
                        4'(mch), mode_tbl[mch]));
                end
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[i])
        begin
            expected_q.push_back(batch[i]);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_total++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result transaction, kind %0d", m_axis_tuser);
            error_total++;
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("kind", want.kind, m_axis_tuser);
            compare_field("led_index", want.led_index, m_axis_tdata[3:0]);
            compare_field("led_level", want.led_level, m_axis_tdata[15:4]);
            compare_field("report_id", want.report_id, m_axis_tdata[23:16]);
            compare_field("out_value", int'(want.out_value), int'($signed(m_axis_tdata[39:24])));
            compare_field("out_channel", want.out_channel, m_axis_tdata[43:40]);
            compare_field("out_mode", want.out_mode, m_axis_tdata[46:44]);
            compare_field("last", want.last, m_axis_tlast);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_tbl[i]   = MODE_UNI_IN;
                drive_tbl[i]  = '0;
                sample_tbl[i] = '0;
                coarse_tbl[i] = '0;
            end
            base_id     = PARAM_BASE_RST;
            last_id     = PARAM_LAST_RST;
            hyst        = HYSTERESIS_RST;
            error_total = 0;
            expected_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                compute_channel_results(s_axis_tuser, s_axis_tdata);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_PARAM_BASE, 2'b00})
                begin
                    base_id = pwdata[7:0];
                end
                else if (paddr == {REG_PARAM_LAST, 2'b00})
                begin
                    last_id = pwdata[7:0];
                end
                else if (paddr == {REG_HYSTERESIS, 2'b00})
                begin
                    hyst = pwdata[6:0];
                end
            end
            mismatch_count <= error_total;
            pending_count  <= expected_q.size();
        end
    end

endmodule

// ----- tb/tb_analog_io_channel_manager_core.sv -----
`timescale 1ns / 100ps
// stimulus, register settings and verdict for the analog i/o channel manager
module tb_analog_io_channel_manager_core;
    import aiocm_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // channel, parameter_id, value, config_channel, new_mode, 4 zero bits
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    // cmd
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // led_index, led_level, report_id, out_value, out_channel, out_mode, 1 zero bit
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    // kind
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     mismatch_count;
    int                     pending_count;
    int                     idle_pct;
    int                     stall_pct;
    int                     cycle_count = 0;
    logic [7:0]             window_base;
    logic [11:0]            recent_sample [CHANNELS];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    analog_io_channel_manager_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    aiocm_result_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [47:0] pack_item(input logic [3:0] ch, input logic [7:0] pid,
                                              input logic [15:0] val, input logic [7:0] code,
                                              input logic [7:0] mode);
        return {4'd0, mode, code, val, pid, ch};
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [47:0] d);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] base, input logic [7:0] last,
                                  input logic [6:0] hyst);
        drain();
        // items without results may still be in flight
        repeat (8) @(posedge clk);
        write_reg(REG_PARAM_BASE, {24'd0, base});
        write_reg(REG_PARAM_LAST, {24'd0, last});
        write_reg(REG_HYSTERESIS, {25'd0, hyst});
        window_base = base;
    endtask

    task automatic random_item(output logic [1:0] cmd, output logic [47:0] d,
                               output bit counted);
        int          pick;
        logic [3:0]  ch;
        logic [7:0]  pid;
        logic [15:0] val;
        logic [7:0]  code;
        logic [7:0]  mode;
        pick    = $urandom_range(0, 99);
        ch      = 4'($urandom);
        pid     = 8'($urandom);
        val     = 16'($urandom);
        code    = 8'($urandom);
        mode    = 8'($urandom);
        counted = 1'b1;
        if (pick < 45)
        begin
            cmd = CMD_SERVICE;
            if ($urandom_range(0, 2) == 0)
            begin
                val[11:0] = recent_sample[ch] + 12'($urandom_range(0, 160)) - 12'd80;
            end
            recent_sample[ch] = val[11:0];
        end
        else if (pick < 70)
        begin
            cmd = CMD_PARAM;
            if ($urandom_range(0, 99) < 85)
            begin
                pid = window_base + 8'($urandom_range(0, 23));
            end
            else
            begin
                counted = 1'b0;
            end
            case ($urandom_range(0, 5))
                0: val = 16'h8000;
                1: val = 16'h7fff;
                2: val = 16'($urandom_range(0, 4095));
                3: val = -16'($urandom_range(1, 2048));
                default: val = 16'($urandom);
            endcase
        end
        else if (pick < 92)
        begin
            cmd = CMD_CONFIG;
            if ($urandom_range(0, 99) < 85)
            begin
                code = 8'($urandom_range(0, 23));
            end
            if ($urandom_range(0, 99) < 80)
            begin
                case ($urandom_range(0, 3))
                    0: mode = 8'(MODE_BIP_IN);
                    1: mode = 8'(MODE_UNI_IN);
                    2: mode = 8'(MODE_BIP_OUT);
                    default: mode = 8'(MODE_UNI_OUT);
                endcase
            end
        end
        else
        begin
            cmd     = CMD_UNKNOWN;
            counted = 1'b0;
        end
        d = pack_item(ch, pid, val, code, mode);
    endtask

    task automatic run_phase(input int items, input int idle, input int stall);
        int          done;
        logic [1:0]  cmd;
        logic [47:0] d;
        bit          counted;
        idle_pct  = idle;
        stall_pct = stall;
        done      = 0;
        while (done < items)
        begin
            random_item(cmd, d, counted);
            send_item(cmd, d);
            if (counted)
            begin
                done++;
                if (done % 100 == 50)
                begin
                    drain();
                end
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        idle_pct      = 0;
        stall_pct     = 0;
        window_base   = PARAM_BASE_RST;
        foreach (recent_sample[i])
        begin
            recent_sample[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset register values
        send_item(CMD_SERVICE, pack_item(4'd0, 8'd0, 16'h0000, 8'd0, 8'd0));
        send_item(CMD_SERVICE, pack_item(4'd0, 8'd0, 16'hffff, 8'd0, 8'd0));
        send_item(CMD_SERVICE, pack_item(4'd15, 8'd0, 16'h0800, 8'd0, 8'd0));
        send_item(CMD_SERVICE, pack_item(4'd15, 8'd0, 16'h0860, 8'd0, 8'd0));
        send_item(CMD_CONFIG, pack_item(4'd0, 8'd0, 16'd0, 8'd23, 8'(MODE_BIP_IN)));
        send_item(CMD_SERVICE, pack_item(4'd0, 8'd0, 16'h7000, 8'd0, 8'd0));
        send_item(CMD_CONFIG, pack_item(4'd0, 8'd0, 16'd0, 8'd8, 8'd7));
        send_item(CMD_CONFIG, pack_item(4'd0, 8'd0, 16'd0, 8'd24, 8'(MODE_UNI_OUT)));
        send_item(CMD_CONFIG, pack_item(4'd0, 8'd0, 16'd0, 8'd255, 8'(MODE_BIP_OUT)));
        send_item(CMD_CONFIG, pack_item(4'd0, 8'd0, 16'd0, 8'd3, 8'(MODE_UNI_IN)));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd1, 16'hffff, 8'd0, 8'd0));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd1, 16'h7fff, 8'd0, 8'd0));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd2, 16'h0000, 8'd0, 8'd0));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd2, 16'h8000, 8'd0, 8'd0));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd2, 16'h8000, 8'd0, 8'd0));
        send_item(CMD_SERVICE, pack_item(4'd2, 8'd0, 16'h0123, 8'd0, 8'd0));
        send_item(CMD_SERVICE, pack_item(4'd1, 8'd0, 16'h0456, 8'd0, 8'd0));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd16, 16'h1234, 8'd0, 8'd0));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd8, 16'd100, 8'd0, 8'd0));
        send_item(CMD_UNKNOWN, 48'h0fff_ffff_ffff);
        send_item(CMD_CONFIG, pack_item(4'd0, 8'd0, 16'd0, 8'd2, 8'hff));
        send_item(CMD_CONFIG, pack_item(4'd0, 8'd0, 16'd0, 8'd1, 8'(MODE_BIP_OUT)));
        send_item(CMD_SERVICE, pack_item(4'd5, 8'd0, 16'h0fff, 8'd0, 8'd0));
        send_item(CMD_PARAM, pack_item(4'd0, 8'd255, 16'h7fff, 8'd0, 8'd0));

        apply_settings(8'd0, 8'd255, 7'd0);
        run_phase(300, 0, 0);
        apply_settings(8'd255, 8'd255, 7'd127);
        run_phase(200, 72, 0);
        apply_settings(8'd8, 8'd40, 7'd1);
        run_phase(300, 0, 72);
        apply_settings(8'd200, 8'd0, 7'd64);
        run_phase(150, 18, 18);
        apply_settings(8'd40, 8'd63, 7'd7);
        run_phase(250, 18, 18);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
